### src/gbn_pkg.sv
package gbn_pkg;

  // field widths fixed by the channel definitions
  localparam int SEQ_BITS       = 16;
  localparam int TIMER_BITS     = 24;
  localparam int WSIZE_BITS     = 6;
  localparam int ERR_BITS       = 8;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 24;

  localparam int DEF_MAX_WINDOW = 32;

  // configuration defaults after reset
  localparam logic [WSIZE_BITS-1:0] RST_WINDOW_SIZE     = WSIZE_BITS'(4);
  localparam logic [SEQ_BITS-1:0]   RST_TOTAL_PACKETS   = '0;
  localparam logic                  RST_ADAPTIVE_ENABLE = 1'b1;
  localparam logic [TIMER_BITS-1:0] RST_TIMEOUT_INITIAL = TIMER_BITS'(100000);
  localparam logic [TIMER_BITS-1:0] RST_TIMEOUT_MIN     = TIMER_BITS'(10000);
  localparam logic [TIMER_BITS-1:0] RST_TIMEOUT_MAX     = TIMER_BITS'(1000000);
  localparam logic [TIMER_BITS-1:0] RST_TIMEOUT_STEP    = TIMER_BITS'(1000);
  localparam logic [ERR_BITS-1:0]   RST_MAX_ERRORS      = ERR_BITS'(10);

  // input commands
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_ERROR = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_SIZE     = 3'd0,
    CFG_TOTAL_PACKETS   = 3'd1,
    CFG_ADAPTIVE_ENABLE = 3'd2,
    CFG_TIMEOUT_INITIAL = 3'd3,
    CFG_TIMEOUT_MIN     = 3'd4,
    CFG_TIMEOUT_MAX     = 3'd5,
    CFG_TIMEOUT_STEP    = 3'd6,
    CFG_MAX_ERRORS      = 3'd7
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic emit;
  } gbn_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic emit_last;
  } gbn_sts_t;

  // one result item
  typedef struct packed {
    logic                  kind;
    logic [SEQ_BITS-1:0]   seq_number;
    logic                  timer_start;
    logic                  timer_stop;
    logic [TIMER_BITS-1:0] timer_interval;
    logic                  done_res;
    logic                  failed;
    logic                  last;
  } gbn_out_t;

endpackage

### src/gbn_in_if.sv
interface gbn_in_if;
  import gbn_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SEQ_BITS-1:0] ack_number;

  modport source (output valid, output command, output ack_number, input ready);
  modport sink   (input valid, input command, input ack_number, output ready);
endinterface

### src/gbn_out_if.sv
interface gbn_out_if;
  import gbn_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [SEQ_BITS-1:0]   seq_number;
  logic                  timer_start;
  logic                  timer_stop;
  logic [TIMER_BITS-1:0] timer_interval;
  logic                  done_res;
  logic                  failed;
  logic                  last;

  modport source (output valid, output kind, output seq_number, output timer_start,
                  output timer_stop, output timer_interval, output done_res,
                  output failed, output last, input ready);
  modport sink   (input valid, input kind, input seq_number, input timer_start,
                  input timer_stop, input timer_interval, input done_res,
                  input failed, input last, output ready);
endinterface

### src/gbn_cfg_if.sv
interface gbn_cfg_if;
  import gbn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/gbn_ctrl.sv
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t cmd
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands, no input transfer while reset is held
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.emit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_exec_follows_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_EXEC && !in_ready))
    else $error("step update did not follow input transfer");

  a_last_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.emit_last) |=> (state_r == S_IDLE))
    else $error("controller kept sending after last result");

endmodule

### src/gbn_dp.sv
module gbn_dp #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gbn_pkg::gbn_cmd_t                   cmd,
  output gbn_pkg::gbn_sts_t                   sts,
  input  logic [1:0]                          in_command,
  input  logic [gbn_pkg::SEQ_BITS-1:0]        in_ack_number,
  input  logic                                cfg_we,
  input  logic [gbn_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gbn_pkg::gbn_out_t                   out_q
);
  import gbn_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int CMP_BITS = (CNT_BITS > WSIZE_BITS) ? CNT_BITS : WSIZE_BITS;
  localparam int SB = SEQ_BITS;
  localparam int TB = TIMER_BITS;

  // configuration registers
  logic [WSIZE_BITS-1:0] window_size_r;
  logic [SB-1:0]         total_packets_r;
  logic                  adaptive_r;
  logic [TB-1:0]         tmo_initial_r;
  logic [TB-1:0]         tmo_min_r;
  logic [TB-1:0]         tmo_max_r;
  logic [TB-1:0]         tmo_step_r;
  logic [ERR_BITS-1:0]   max_errors_r;

  // window state
  logic [SB-1:0]       base_r, base_nxt;
  logic [SB-1:0]       next_r, next_nxt;
  logic [SB-1:0]       wlast_r, wlast_nxt;
  logic [SB-1:0]       acked_r, acked_nxt;
  logic [ERR_BITS-1:0] err_r, err_nxt;
  logic                trun_r, trun_nxt;
  logic [TB-1:0]       tv_r, tv_nxt;

  // per-step registers
  cmd_t                cmd_r;
  logic [SB-1:0]       ack_r;
  logic                send_en_r, send_en_nxt;
  logic                started_r, started_nxt;
  logic                stopped_r, stopped_nxt;
  logic [CNT_BITS-1:0] cnt_r;

  logic     out_valid_r;
  gbn_out_t out_r, out_nxt;

  // effective window: zero acts as one, clamp at the maximum
  logic [CMP_BITS-1:0] ws_ext, eff_w;
  assign ws_ext = CMP_BITS'(window_size_r);
  always_comb begin
    if (ws_ext == '0) begin
      eff_w = CMP_BITS'(1);
    end else if (ws_ext > CMP_BITS'(MAX_WINDOW)) begin
      eff_w = CMP_BITS'(MAX_WINDOW);
    end else begin
      eff_w = ws_ext;
    end
  end

  // window end: min(base + window - 1, total), base is 1 on start or ack + 1
  logic [SB:0]   wend;
  logic [SB-1:0] wlast_new;
  assign wend      = {1'b0, (cmd_r == CMD_START) ? '0 : ack_r} + (SB+1)'(eff_w);
  assign wlast_new = (wend < {1'b0, total_packets_r}) ? wend[SB-1:0] : total_packets_r;

  // adaptive timeout up and down
  logic [TB:0]   tv_sum, tv_thr;
  logic          raise_ok, lower_ok;
  logic [TB-1:0] tv_raised, tv_lowered;
  assign tv_sum     = {1'b0, tv_r} + {1'b0, tmo_step_r};
  assign tv_thr     = {1'b0, tmo_min_r} + {1'b0, tmo_step_r};
  assign raise_ok   = adaptive_r && (tv_sum <= {1'b0, tmo_max_r});
  assign lower_ok   = adaptive_r && ({1'b0, tv_r} >= tv_thr);
  assign tv_raised  = raise_ok ? tv_sum[TB-1:0] : tv_r;
  assign tv_lowered = lower_ok ? (tv_r - tmo_step_r) : tv_r;

  // transfer status
  logic                done, failed;
  logic [ERR_BITS-1:0] err_lim;
  assign err_lim = (max_errors_r == '0) ? ERR_BITS'(1) : max_errors_r;
  assign done    = (acked_r == total_packets_r);
  assign failed  = (err_r >= err_lim);

  // step update
  logic ack_ok;
  assign ack_ok = (ack_r >= base_r) && (ack_r <= wlast_r);

  always_comb begin
    base_nxt    = base_r;
    next_nxt    = next_r;
    wlast_nxt   = wlast_r;
    acked_nxt   = acked_r;
    err_nxt     = err_r;
    trun_nxt    = trun_r;
    tv_nxt      = tv_r;
    send_en_nxt = 1'b0;
    started_nxt = 1'b0;
    stopped_nxt = 1'b0;
    case (cmd_r)
      CMD_START: begin
        base_nxt    = SB'(1);
        next_nxt    = SB'(1);
        acked_nxt   = '0;
        err_nxt     = '0;
        trun_nxt    = 1'b0;
        tv_nxt      = tmo_initial_r;
        wlast_nxt   = wlast_new;
        send_en_nxt = 1'b1;
      end
      CMD_ACK: begin
        if (!done && !failed) begin
          if (ack_ok) begin
            tv_nxt    = tv_lowered;
            wlast_nxt = wlast_new;
            base_nxt  = ack_r + SB'(1);
            acked_nxt = ack_r;
            trun_nxt  = 1'b1;
            if (ack_r == total_packets_r) begin
              stopped_nxt = 1'b1;
            end else begin
              started_nxt = 1'b1;
              send_en_nxt = 1'b1;
            end
          end else if (ack_r < base_r) begin
            tv_nxt = tv_raised;
          end
        end
      end
      CMD_ERROR: begin
        if (!done && !failed) begin
          if (err_r != '1) begin
            err_nxt = err_r + ERR_BITS'(1);
          end
          if (adaptive_r) begin
            tv_nxt   = tv_raised;
            trun_nxt = 1'b0;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (!done && !failed) begin
          tv_nxt      = tv_raised;
          trun_nxt    = 1'b0;
          next_nxt    = base_r;
          send_en_nxt = 1'b1;
        end
      end
      default: begin
        send_en_nxt = 1'b0;
      end
    endcase
  end

  // send sequencer: one result per free output slot
  logic          cur_ok, nxt_ok;
  logic [SB-1:0] next_inc;
  logic [CNT_BITS:0] cnt_inc;
  assign next_inc = next_r + SB'(1);
  assign cnt_inc  = {1'b0, cnt_r} + (CNT_BITS+1)'(1);
  assign cur_ok   = send_en_r && (next_r <= wlast_r) && (cnt_r < CNT_BITS'(MAX_WINDOW));
  assign nxt_ok   = (next_inc <= wlast_r) && (cnt_inc < (CNT_BITS+1)'(MAX_WINDOW));

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.emit_last = !cur_ok || !nxt_ok;

  // result assembly
  always_comb begin
    out_nxt.kind           = cur_ok;
    out_nxt.seq_number     = cur_ok ? next_r : '0;
    out_nxt.timer_start    = (cnt_r == '0) && (started_r || (cur_ok && !trun_r));
    out_nxt.timer_stop     = (cnt_r == '0) && stopped_r;
    out_nxt.timer_interval = tv_r;
    out_nxt.done_res       = done;
    out_nxt.failed         = failed;
    out_nxt.last           = sts.emit_last;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= RST_WINDOW_SIZE;
      total_packets_r <= RST_TOTAL_PACKETS;
      adaptive_r      <= RST_ADAPTIVE_ENABLE;
      tmo_initial_r   <= RST_TIMEOUT_INITIAL;
      tmo_min_r       <= RST_TIMEOUT_MIN;
      tmo_max_r       <= RST_TIMEOUT_MAX;
      tmo_step_r      <= RST_TIMEOUT_STEP;
      max_errors_r    <= RST_MAX_ERRORS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_SIZE:     window_size_r   <= cfg_data[WSIZE_BITS-1:0];
        CFG_TOTAL_PACKETS:   total_packets_r <= cfg_data[SB-1:0];
        CFG_ADAPTIVE_ENABLE: adaptive_r      <= cfg_data[0];
        CFG_TIMEOUT_INITIAL: tmo_initial_r   <= cfg_data[TB-1:0];
        CFG_TIMEOUT_MIN:     tmo_min_r       <= cfg_data[TB-1:0];
        CFG_TIMEOUT_MAX:     tmo_max_r       <= cfg_data[TB-1:0];
        CFG_TIMEOUT_STEP:    tmo_step_r      <= cfg_data[TB-1:0];
        CFG_MAX_ERRORS:      max_errors_r    <= cfg_data[ERR_BITS-1:0];
        default: begin
          max_errors_r <= max_errors_r;
        end
      endcase
    end
  end

  // input capture, payload only, and per-step send flags on state update
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= cmd_t'(in_command);
      ack_r <= in_ack_number;
    end
    if (cmd.exec) begin
      send_en_r <= send_en_nxt;
      started_r <= started_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // window state and sequencer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= SB'(1);
      next_r  <= SB'(1);
      wlast_r <= '0;
      acked_r <= '0;
      err_r   <= '0;
      trun_r  <= 1'b0;
      tv_r    <= RST_TIMEOUT_INITIAL;
      cnt_r   <= '0;
    end else if (cmd.exec) begin
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      wlast_r <= wlast_nxt;
      acked_r <= acked_nxt;
      err_r   <= err_nxt;
      trun_r  <= trun_nxt;
      tv_r    <= tv_nxt;
      cnt_r   <= '0;
    end else if (cmd.emit && cur_ok) begin
      next_r <= next_inc;
      trun_r <= 1'b1;
      cnt_r  <= cnt_inc[CNT_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_q     = out_r;

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (cnt_r < CNT_BITS'(MAX_WINDOW)))
    else $error("more packets in one step than the window allows");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !cur_ok) |-> (cnt_r == '0))
    else $error("status result after packets of the same step");

  a_stop_means_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.timer_stop) |-> (out_r.done_res && !out_r.timer_start))
    else $error("timer stop without completed transfer");

endmodule

### src/go_back_n_sender_window_core.sv
// channel  dir  handshake      payload
// in_ch    in   valid/ready    command, ack_number
// out_ch   out  valid/ready    kind, seq_number, timer_start/stop, timer_interval, flags, last
// cfg_ch   in   valid/ready    index, data (ready high whenever out of reset)
//
// an input is captured, then the window state is updated, then the results are sent;
// a step gives 1 to MAX_WINDOW results, set by the send sequencer that, unless
// out_ready holds it, walks the window one sequence number per cycle via the output register
// rst_n is synchronous; it clears the window state and loads the register defaults
// out_ready low holds the sequencer; in_ready is high only between steps
module go_back_n_sender_window_core #(
  parameter int MAX_WINDOW = gbn_pkg::DEF_MAX_WINDOW
) (
  input logic      clk,
  input logic      rst_n,
  gbn_in_if.sink   in_ch,
  gbn_out_if.source out_ch,
  gbn_cfg_if.sink  cfg_ch
);
  import gbn_pkg::*;

  gbn_cmd_t ctl_cmd;
  gbn_sts_t dp_sts;
  gbn_out_t out_q;

  // config writes are taken whenever out of reset
  assign cfg_ch.ready = rst_n;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  gbn_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctl_cmd),
    .sts           (dp_sts),
    .in_command    (in_ch.command),
    .in_ack_number (in_ch.ack_number),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_q         (out_q)
  );

  // result transfer fields
  assign out_ch.kind           = out_q.kind;
  assign out_ch.seq_number     = out_q.seq_number;
  assign out_ch.timer_start    = out_q.timer_start;
  assign out_ch.timer_stop     = out_q.timer_stop;
  assign out_ch.timer_interval = out_q.timer_interval;
  assign out_ch.done_res       = out_q.done_res;
  assign out_ch.failed         = out_q.failed;
  assign out_ch.last           = out_q.last;

endmodule
